FILE: rtl/core/sme_pkg.sv
// package for the stack machine executor: opcodes, status codes, sizes
// no dependencies
package sme_pkg;

    localparam int StackDepth  = 1024;
    localparam int GlobalCount = 256;
    localparam int SpW         = $clog2(StackDepth + 1);
    localparam int SaW         = $clog2(StackDepth);
    localparam int GaW         = (GlobalCount > 1) ? $clog2(GlobalCount) : 1;

    localparam logic [31:0] FillValue = 32'hFFFF_FF9D;

    typedef enum logic [7:0] {
        OP_HALT  = 8'd0,  OP_PUSHC = 8'd1,  OP_ADD   = 8'd2,  OP_SUB   = 8'd3,
        OP_MUL   = 8'd4,  OP_DIV   = 8'd5,  OP_MOD   = 8'd6,  OP_RDINT = 8'd7,
        OP_WRINT = 8'd8,  OP_RDCHR = 8'd9,  OP_WRCHR = 8'd10, OP_PUSHG = 8'd11,
        OP_POPG  = 8'd12, OP_ASF   = 8'd13, OP_RSF   = 8'd14, OP_PUSHL = 8'd15,
        OP_POPL  = 8'd16, OP_EQ    = 8'd17, OP_NE    = 8'd18, OP_LT    = 8'd19,
        OP_LE    = 8'd20, OP_GT    = 8'd21, OP_GE    = 8'd22, OP_JMP   = 8'd23,
        OP_BRF   = 8'd24, OP_BRT   = 8'd25, OP_CALL  = 8'd26, OP_RET   = 8'd27,
        OP_DROP  = 8'd28, OP_PUSHR = 8'd29, OP_POPR  = 8'd30, OP_DUP   = 8'd31
    } t_op;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_DIV0 = 3'd1,
        ST_TAG  = 3'd2,
        ST_OPC  = 3'd3,
        ST_RNG  = 3'd4
    } t_status;

endpackage

FILE: rtl/core/stack_machine_executor_core.sv
// Executes one instruction word per beat on a tagged operand stack. After reset the block
// sweeps the stack memory once, one slot per cycle, refilling every slot with object -99,
// and takes no beat meanwhile. Up to two stack reads go one after another through the
// single read port of the stack memory, a second write back goes through its own state, and
// div and mod go through a one-bit-per-cycle divider. The block then returns to idle through
// the output state, so it takes no new beat before the last one is through, and a result
// still waiting in the output register holds off the next beat. Once halted, a beat is
// answered with a halted result and not executed. Depends on sme_pkg.
module stack_machine_executor_core
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction_word,
    input  logic signed [31:0] i_read_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_next_pc,
    output logic        o_write_valid,
    output logic        o_write_is_char,
    output logic signed [31:0] o_write_value,
    output logic        o_halted,
    output logic [2:0]  o_status
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_WR2, S_OUT
    } t_state;

    // memories
    logic [32:0] r_stack [StackDepth];
    logic [31:0] r_glob  [GlobalCount];
    logic [32:0] r_srd;
    logic [31:0] r_grd;

    logic         s_we;
    logic [SaW-1:0] s_wa, s_ra;
    logic [32:0]  s_wd;
    logic         g_we;

    t_state       r_state;
    logic [SaW-1:0] r_clr;
    logic [SpW-1:0] r_sp, r_fp;
    logic [23:0]  r_pc;
    logic [31:0]  r_rr;
    logic         r_halt;
    logic [31:0]  r_iw, r_rv;
    logic [32:0]  r_a, r_b;      // a = slot sp-2 (or fp-1/idx), b = slot sp-1
    logic [SaW-1:0] r_wa2;
    logic [32:0]  r_wd2;
    // divider
    logic [5:0]   r_dcnt;
    logic [31:0]  r_q, r_dv;
    logic [32:0]  r_rem;
    logic         r_qn, r_rn;
    // output register
    logic         r_ov;
    logic [23:0]  r_opc;
    logic         r_owv, r_owc, r_oh;
    logic [31:0]  r_owval;
    logic [2:0]   r_ost;

    t_op          op;
    logic signed [24:0] imm;
    logic [23:0]  immpc;
    logic signed [25:0] sps, fps, idx;

    assign op    = t_op'(r_iw[31:24]);
    assign imm   = {r_iw[23], r_iw[23:0]};
    assign immpc = r_iw[23:0];
    assign sps   = $signed(26'(r_sp));
    assign fps   = $signed(26'(r_fp));
    assign idx   = fps + 26'(imm);

    localparam logic signed [25:0] DepS = 26'(StackDepth);

    logic in_local;
    assign in_local = (idx >= 0) && (idx < DepS);
    logic g_ok;
    assign g_ok = (imm >= 0) && (imm < 25'(GlobalCount));
    logic [GaW-1:0] gidx;
    assign gidx = GaW'(r_iw[23:0]);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_stack[s_wa] <= s_wd;
        end
        r_srd <= r_stack[s_ra];
        if (g_we) begin
            r_glob[gidx] <= r_b[31:0];
        end
        r_grd <= r_glob[gidx];
    end

    // classes
    logic c_bin;
    always_comb begin
        c_bin  = 1'b0;
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: c_bin = 1'b1;
            default: ;
        endcase
    end

    // read address by state
    always_comb begin
        s_ra = SaW'(r_sp - SpW'(1));
        case (r_state)
            S_IDLE: s_ra = SaW'(i_in_valid ? r_sp - SpW'(1) : r_sp - SpW'(1));
            S_RD1: begin
                if (c_bin) s_ra = SaW'(r_sp - SpW'(2));
                else if (op == OP_RSF) s_ra = SaW'(r_fp - SpW'(1));
                else s_ra = SaW'(idx);
            end
            default: ;
        endcase
    end

    // execute
    logic signed [31:0] sa, sb;
    assign sa = $signed(r_a[31:0]);
    assign sb = $signed(r_b[31:0]);
    logic [31:0] mulr;
    assign mulr = r_a[31:0] * r_b[31:0];

    logic [2:0]  x_st;
    logic        x_w1, x_w2, x_wv, x_wc, x_div, x_halt;
    logic [SaW-1:0] x_wa1, x_wa2;
    logic [32:0] x_wd1, x_wd2;
    logic [SpW-1:0] x_sp, x_fp;
    logic [23:0] x_pc;
    logic [31:0] x_rr, x_wval;
    logic [23:0] pc1;
    assign pc1 = r_pc + 24'd1;
    logic [32:0] fill;
    assign fill = {1'b1, FillValue};

    always_comb begin
        x_st = ST_OK; x_w1 = 1'b0; x_w2 = 1'b0; x_wv = 1'b0; x_wc = 1'b0;
        x_div = 1'b0; x_halt = 1'b0;
        x_wa1 = SaW'(r_sp); x_wa2 = SaW'(r_sp - SpW'(1));
        x_wd1 = fill; x_wd2 = fill;
        x_sp = r_sp; x_fp = r_fp; x_pc = pc1; x_rr = r_rr; x_wval = '0;
        case (op)
            OP_HALT: x_halt = 1'b1;
            OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHG, OP_PUSHR: begin
                if (r_sp >= SpW'(StackDepth)) x_st = ST_RNG;
                else if (op == OP_PUSHG && !g_ok) x_st = ST_RNG;
                else begin
                    x_w1 = 1'b1;
                    case (op)
                        OP_PUSHC: x_wd1 = {1'b1, 32'(imm)};
                        OP_RDINT: x_wd1 = {1'b1, r_rv};
                        OP_RDCHR: x_wd1 = {1'b1, 24'd0, r_rv[7:0]};
                        OP_PUSHG: x_wd1 = {1'b1, r_grd};
                        default:  x_wd1 = {1'b1, r_rr};
                    endcase
                    x_sp = r_sp + SpW'(1);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
                if (r_sp < SpW'(2)) x_st = ST_RNG;
                else if (!r_a[32] || !r_b[32]) x_st = ST_TAG;
                else if ((op == OP_DIV || op == OP_MOD) && r_b[31:0] == 32'd0)
                    x_st = ST_DIV0;
                else begin
                    x_w1 = 1'b1; x_w2 = 1'b1;
                    x_wa1 = SaW'(r_sp - SpW'(2));
                    x_sp = r_sp - SpW'(1);
                    case (op)
                        OP_ADD: x_wd1 = {1'b1, r_a[31:0] + r_b[31:0]};
                        OP_SUB: x_wd1 = {1'b1, r_a[31:0] - r_b[31:0]};
                        OP_MUL: x_wd1 = {1'b1, mulr};
                        OP_EQ:  x_wd1 = {1'b0, 31'd0, sa == sb};
                        OP_NE:  x_wd1 = {1'b0, 31'd0, sa != sb};
                        OP_LT:  x_wd1 = {1'b0, 31'd0, sa <  sb};
                        OP_LE:  x_wd1 = {1'b0, 31'd0, sa <= sb};
                        OP_GT:  x_wd1 = {1'b0, 31'd0, sa >  sb};
                        OP_GE:  x_wd1 = {1'b0, 31'd0, sa >= sb};
                        default: x_div = 1'b1;
                    endcase
                end
            end
            OP_WRINT, OP_WRCHR, OP_POPG, OP_POPR: begin
                if (r_sp < SpW'(1)) x_st = ST_RNG;
                else if (op == OP_POPG && !g_ok) x_st = ST_RNG;
                else if (!r_b[32]) x_st = ST_TAG;
                else begin
                    x_w1 = 1'b1; x_wa1 = SaW'(r_sp - SpW'(1));
                    x_sp = r_sp - SpW'(1);
                    if (op == OP_POPR) x_rr = r_b[31:0];
                    else if (op != OP_POPG) begin
                        x_wv = 1'b1; x_wc = (op == OP_WRCHR); x_wval = r_b[31:0];
                    end
                end
            end
            OP_ASF: begin
                if (r_sp >= SpW'(StackDepth) || imm < 0
                    || sps + 1 + 26'(imm) > DepS) x_st = ST_RNG;
                else begin
                    x_w1 = 1'b1; x_wd1 = {1'b0, 32'(r_fp)};
                    x_fp = r_sp + SpW'(1);
                    x_sp = SpW'(sps + 1 + 26'(imm));
                end
            end
            OP_RSF: begin
                if (r_fp < SpW'(1) || r_fp > SpW'(StackDepth)) x_st = ST_RNG;
                else if (r_a[32]) x_st = ST_TAG;
                else if (r_a[31:0] > 32'(StackDepth)) x_st = ST_RNG;
                else begin
                    x_w1 = 1'b1; x_wa1 = SaW'(r_fp - SpW'(1));
                    x_sp = r_fp - SpW'(1); x_fp = SpW'(r_a[31:0]);
                end
            end
            OP_PUSHL: begin
                if (!in_local || r_sp >= SpW'(StackDepth)) x_st = ST_RNG;
                else if (!r_a[32]) x_st = ST_TAG;
                else begin
                    x_w1 = 1'b1; x_wd1 = r_a; x_sp = r_sp + SpW'(1);
                end
            end
            OP_POPL: begin
                if (r_sp < SpW'(1) || !in_local) x_st = ST_RNG;
                else if (!r_b[32]) x_st = ST_TAG;
                else begin
                    // refill first, then the local, so idx == sp-1 ends with the value
                    x_w1 = 1'b1; x_wa1 = SaW'(r_sp - SpW'(1));
                    x_w2 = 1'b1; x_wa2 = SaW'(idx); x_wd2 = r_b;
                    x_sp = r_sp - SpW'(1);
                end
            end
            OP_JMP: x_pc = immpc;
            OP_BRF, OP_BRT, OP_RET: begin
                if (r_sp < SpW'(1)) x_st = ST_RNG;
                else if (r_b[32]) x_st = ST_TAG;
                else begin
                    x_w1 = 1'b1; x_wa1 = SaW'(r_sp - SpW'(1));
                    x_sp = r_sp - SpW'(1);
                    if (op == OP_RET) x_pc = r_b[23:0];
                    else if ((op == OP_BRF && r_b[31:0] == 32'd0)
                          || (op == OP_BRT && r_b[31:0] == 32'd1)) x_pc = immpc;
                end
            end
            OP_CALL: begin
                if (r_sp >= SpW'(StackDepth)) x_st = ST_RNG;
                else begin
                    x_w1 = 1'b1; x_wd1 = {1'b0, 8'd0, pc1};
                    x_sp = r_sp + SpW'(1); x_pc = immpc;
                end
            end
            OP_DROP: begin
                if (imm < 0 || imm > sps[24:0]) x_st = ST_RNG;
                else x_sp = SpW'(sps - 26'(imm));
            end
            OP_DUP: begin
                if (r_sp < SpW'(1) || r_sp >= SpW'(StackDepth)) x_st = ST_RNG;
                else begin
                    x_w1 = 1'b1; x_wd1 = r_b; x_sp = r_sp + SpW'(1);
                end
            end
            default: x_st = ST_OPC;
        endcase
        if (x_st != ST_OK) begin
            x_w1 = 1'b0; x_w2 = 1'b0; x_wv = 1'b0; x_div = 1'b0;
            x_sp = r_sp; x_fp = r_fp; x_pc = pc1; x_rr = r_rr; x_halt = 1'b1;
        end
    end

    // divider on magnitudes
    logic [32:0] rem_sh, rem_sub;
    assign rem_sh  = {r_rem[31:0], r_q[31]};
    assign rem_sub = rem_sh - {1'b0, r_dv};
    logic [31:0] dres;
    always_comb begin
        if (op == OP_DIV) dres = r_qn ? -r_q : r_q;
        else dres = r_rn ? -r_rem[31:0] : r_rem[31:0];
    end

    always_comb begin
        s_we = 1'b0; s_wa = x_wa1; s_wd = x_wd1; g_we = 1'b0;
        case (r_state)
            S_CLEAR: begin
                s_we = 1'b1; s_wa = r_clr; s_wd = fill;
            end
            S_EXEC: begin
                s_we = x_w1 && !x_div; g_we = (op == OP_POPG) && x_st == ST_OK;
            end
            S_DIV: begin
                // sp already lowered by one, so the result slot is sp-1
                s_we = (r_dcnt == 6'd0); s_wd = {1'b1, dres};
                s_wa = SaW'(r_sp - SpW'(1));
            end
            S_WR2: begin
                s_we = 1'b1; s_wa = r_wa2; s_wd = r_wd2;
            end
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE) || (r_ov && i_out_stall);

    // a new result is loaded into the output register this cycle
    logic ov_set;
    assign ov_set = (r_state == S_IDLE && i_in_valid && !o_in_stall && r_halt)
                 || (r_state == S_OUT && (!r_ov || !i_out_stall));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_sp    <= '0;
            r_fp    <= '0;
            r_pc    <= '0;
            r_rr    <= '0;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall && !ov_set) r_ov <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SaW'(1);
                    if (r_clr == SaW'(StackDepth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_iw <= i_instruction_word;
                        r_rv <= i_read_value;
                        if (r_halt) begin
                            r_ov <= 1'b1; r_opc <= r_pc; r_owv <= 1'b0;
                            r_owc <= 1'b0; r_owval <= '0; r_oh <= 1'b1;
                            r_ost <= ST_OK;
                        end else begin
                            r_state <= S_RD1;
                        end
                    end
                end
                S_RD1: begin
                    r_b <= r_srd;
                    r_state <= (c_bin || op == OP_RSF || op == OP_PUSHL) ? S_RD2 : S_EXEC;
                end
                S_RD2: begin
                    r_a <= r_srd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_wa2 <= x_wa2; r_wd2 <= x_wd2;
                    r_sp <= x_sp; r_fp <= x_fp; r_pc <= x_pc; r_rr <= x_rr;
                    r_opc <= x_pc; r_owv <= x_wv; r_owc <= x_wc; r_owval <= x_wval;
                    r_ost <= x_st; r_oh <= x_halt;
                    r_halt <= x_halt;
                    if (x_div) begin
                        r_dcnt <= 6'd32;
                        r_q    <= sa[31] ? -r_a[31:0] : r_a[31:0];
                        r_dv   <= sb[31] ? -r_b[31:0] : r_b[31:0];
                        r_rem  <= '0;
                        r_qn   <= sa[31] ^ sb[31];
                        r_rn   <= sa[31];
                        r_state <= S_DIV;
                    end else if (x_w2) begin
                        r_state <= S_WR2;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 6'd0) begin
                        r_state <= S_WR2;
                    end else begin
                        r_dcnt <= r_dcnt - 6'd1;
                        if (!rem_sub[32]) begin
                            r_rem <= rem_sub; r_q <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh; r_q <= {r_q[30:0], 1'b0};
                        end
                    end
                end
                S_WR2: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_next_pc       = r_opc;
    assign o_write_valid   = r_owv;
    assign o_write_is_char = r_owc;
    assign o_write_value   = r_owval;
    assign o_halted        = r_oh;
    assign o_status        = r_ost;

    // no beat is taken during the clearing sweep
    a_no_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("beat accepted during clear");
    // an error always leaves the block halted
    a_err_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_halted)
        else $error("error without halt");
    // stack pointer stays within depth
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SpW'(StackDepth))
        else $error("stack pointer out of range");
    // once halted, the pc never changes
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) && r_halt |-> $stable(r_pc))
        else $error("pc moved after halt");

endmodule
